// ----- rtl/ddts_pkg.sv -----
`default_nettype none

package ddts_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DRIFT_STEP        = 3'd0,
        CFG_POST_DRIFT_STEP   = 3'd1,
        CFG_NOISE_SCALE       = 3'd2,
        CFG_UPPER_BOUND       = 3'd3,
        CFG_START_LEVEL       = 3'd4,
        CFG_NONDECISION_STEPS = 3'd5
    } t_cfg_idx;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned LEVEL_W     = 32;
    localparam int unsigned BOUND_W     = 31;
    localparam int unsigned SCALE_W     = 16;
    localparam int unsigned NOISE_W     = 16;
    localparam int unsigned POST_W      = 16;
    localparam int unsigned NDT_W       = 24;
    localparam int unsigned OUT_TIME_W  = 32;
    // Scaled noise term: floor(noise * scale / 2^12) always fits in 20 signed bits.
    localparam int unsigned NTERM_W     = 20;

    localparam logic [BOUND_W-1:0] UPPER_BOUND_RST = 31'd65536;
    localparam logic [BOUND_W-1:0] START_LEVEL_RST = 31'd32768;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 136;

    // Result item as packed on the master-side tdata (last member in the lowest bits).
    typedef struct packed {
        logic [5:0]             pad;
        logic [LEVEL_W-1:0]     confidence;
        logic [OUT_TIME_W-1:0]  total_time;
        logic [LEVEL_W-1:0]     final_evidence;
        logic                   correct;
        logic                   response;
        logic [OUT_TIME_W-1:0]  decision_time;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/ddts_time_out.sv -----
`default_nettype none

// Adds the non-decision steps to a step count, saturates at the count's full
// scale and then at the 32-bit range of the reported time.
module ddts_time_out #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic [TIME_BITS-1:0]           i_steps,
    input  wire logic [ddts_pkg::NDT_W-1:0]     i_extra,
    output logic      [ddts_pkg::OUT_TIME_W-1:0] o_time
);

    localparam int unsigned SW =
        ((TIME_BITS > ddts_pkg::NDT_W) ? TIME_BITS : ddts_pkg::NDT_W) + 1;

    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_max;
    logic [SW-1:0] w_sat;

    assign w_sum = SW'(i_steps) + SW'(i_extra);
    assign w_max = {{(SW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
    assign w_sat = (w_sum > w_max) ? w_max : w_sum;

    generate
        if (SW > ddts_pkg::OUT_TIME_W) begin : g_wide
            assign o_time = (|w_sat[SW-1:ddts_pkg::OUT_TIME_W]) ?
                            {ddts_pkg::OUT_TIME_W{1'b1}} :
                            w_sat[ddts_pkg::OUT_TIME_W-1:0];
        end else begin : g_narrow
            assign o_time = ddts_pkg::OUT_TIME_W'(w_sat);
        end
    endgenerate

endmodule

`default_nettype wire

// ----- rtl/drift_diffusion_trial_stepper_core.sv -----
`default_nettype none

// Drift-diffusion trial stepper. Every transfer on the slave-side stream is one
// time step of a trial and carries one standard-normal noise sample in Q4.12;
// a trial starts at the start level, adds the drift step and the scaled noise
// on each step until the evidence reaches the upper bound or falls to zero,
// clamps it there, and then runs the number of post-decision steps given on the
// deciding item at the post-decision drift. One result transfer leaves per
// trial, carrying decision time, response, correctness, final evidence, total
// time and confidence. The block takes one step per clock cycle when the
// result side is not stalled: the first stage registers the noise multiplied
// by the noise scale, the second adds it to the running evidence, compares
// against both bounds and loads the output register, so a result is offered on
// the result stream from the output register once the step that ends the
// trial has passed the input register; a stalled result side can hold it there.
// A finished result is held in an output register while one further step
// waits in the input register. Configuration writes are taken in every
// cycle and are meant to be made while no step is in flight; a change of start
// level acts on the next trial.
module drift_diffusion_trial_stepper_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Step stream.
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // From bit 0: noise[15:0], post_steps[31:16].
    input  wire logic [ddts_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // Result stream.
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // From bit 0: decision_time[31:0], response[32], correct[33],
    // final_evidence[65:34], total_time[97:66], confidence[129:98], zeros.
    output logic      [ddts_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ddts_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [ddts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned LW = ddts_pkg::LEVEL_W;

    // Saturates a 34-bit signed sum to the signed 32-bit range.
    function automatic logic [LW-1:0] sat_level(input logic signed [LW+1:0] x);
        logic signed [LW+1:0] hi;
        logic signed [LW+1:0] lo;
        hi = {3'b000, {(LW-1){1'b1}}};
        lo = {3'b111, {(LW-1){1'b0}}};
        if (x > hi) begin
            sat_level = hi[LW-1:0];
        end else if (x < lo) begin
            sat_level = lo[LW-1:0];
        end else begin
            sat_level = x[LW-1:0];
        end
    endfunction

    // Configuration registers.
    logic signed [LW-1:0]                   r_drift;
    logic signed [LW-1:0]                   r_post_drift;
    logic [ddts_pkg::SCALE_W-1:0]           r_noise_scale;
    logic [ddts_pkg::BOUND_W-1:0]           r_upper_bound;
    logic [ddts_pkg::BOUND_W-1:0]           r_start_level;
    logic [ddts_pkg::NDT_W-1:0]             r_nd_steps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift       <= '0;
            r_post_drift  <= '0;
            r_noise_scale <= '0;
            r_upper_bound <= ddts_pkg::UPPER_BOUND_RST;
            r_start_level <= ddts_pkg::START_LEVEL_RST;
            r_nd_steps    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ddts_pkg::t_cfg_idx'(i_cfg_index))
                ddts_pkg::CFG_DRIFT_STEP:        r_drift       <= i_cfg_data;
                ddts_pkg::CFG_POST_DRIFT_STEP:   r_post_drift  <= i_cfg_data;
                ddts_pkg::CFG_NOISE_SCALE:
                    r_noise_scale <= i_cfg_data[ddts_pkg::SCALE_W-1:0];
                ddts_pkg::CFG_UPPER_BOUND:
                    r_upper_bound <= i_cfg_data[ddts_pkg::BOUND_W-1:0];
                ddts_pkg::CFG_START_LEVEL:
                    r_start_level <= i_cfg_data[ddts_pkg::BOUND_W-1:0];
                ddts_pkg::CFG_NONDECISION_STEPS:
                    r_nd_steps    <= i_cfg_data[ddts_pkg::NDT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: scale the noise sample. The product of a signed Q4.12 sample
    // and an unsigned Q0.16 scale is shifted down by twelve; taking the upper
    // bits of the two's complement product rounds towards minus infinity.
    // ------------------------------------------------------------------
    logic signed [ddts_pkg::NOISE_W-1:0]    w_noise;
    logic signed [LW:0]                     w_prod;
    logic                                   w_adv;
    logic                                   r_s1_valid;
    logic signed [ddts_pkg::NTERM_W-1:0]    r_s1_nterm;
    logic [ddts_pkg::POST_W-1:0]            r_s1_post_steps;

    assign w_noise    = i_s_tdata[ddts_pkg::NOISE_W-1:0];
    assign w_prod     = w_noise * $signed({1'b0, r_noise_scale});
    assign o_s_tready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_s1_nterm      <= w_prod[ddts_pkg::NTERM_W+11:12];
            r_s1_post_steps <= i_s_tdata[ddts_pkg::NOISE_W+ddts_pkg::POST_W-1:ddts_pkg::NOISE_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: evidence update, bound checks and trial bookkeeping.
    // ------------------------------------------------------------------
    logic signed [LW-1:0]            r_level;
    logic [TIME_BITS-1:0]            r_step_count;
    logic [TIME_BITS-1:0]            r_dec_steps;
    logic                            r_in_post;
    logic                            r_chose_upper;
    logic                            r_was_correct;
    logic [ddts_pkg::POST_W-1:0]     r_post_left;

    logic signed [LW-1:0]            w_base;
    logic signed [LW-1:0]            w_drift_sel;
    logic signed [LW+1:0]            w_sum;
    logic signed [LW-1:0]            w_sat;
    logic signed [LW:0]              w_bound_s;
    logic                            w_hit_up;
    logic                            w_hit_lo;
    logic                            w_decide;
    logic signed [LW-1:0]            w_level_nx;
    logic [TIME_BITS-1:0]            w_cnt_nx;
    logic [ddts_pkg::POST_W-1:0]     w_post_dec;
    logic                            w_emit;
    logic                            w_resp;
    logic                            w_corr;
    logic [TIME_BITS-1:0]            w_dec_nx;
    logic signed [LW+1:0]            w_conf_raw;
    logic [ddts_pkg::OUT_TIME_W-1:0] w_dec_time;
    logic [ddts_pkg::OUT_TIME_W-1:0] w_tot_time;
    ddts_pkg::t_result               w_result;

    // The first step of a trial starts from the start level register.
    assign w_base = r_in_post ? r_level :
                    ((r_step_count == '0) ? $signed({1'b0, r_start_level}) : r_level);
    assign w_drift_sel = r_in_post ? r_post_drift : r_drift;
    assign w_sum = {{2{w_base[LW-1]}}, w_base}
                 + {{2{w_drift_sel[LW-1]}}, w_drift_sel}
                 + {{(LW+2-ddts_pkg::NTERM_W){r_s1_nterm[ddts_pkg::NTERM_W-1]}}, r_s1_nterm};
    assign w_sat = sat_level(w_sum);

    assign w_bound_s = $signed({2'b00, r_upper_bound});
    assign w_hit_up  = !r_in_post && ($signed({w_sat[LW-1], w_sat}) >= w_bound_s);
    assign w_hit_lo  = !r_in_post && !w_hit_up && (w_sat <= 0);
    assign w_decide  = w_hit_up || w_hit_lo;

    assign w_level_nx = w_hit_up ? $signed({1'b0, r_upper_bound}) :
                        (w_hit_lo ? '0 : w_sat);
    assign w_cnt_nx   = (r_step_count == {TIME_BITS{1'b1}}) ? r_step_count
                                                            : r_step_count + 1'b1;
    assign w_post_dec = r_post_left - 1'b1;

    assign w_emit = w_decide ? (r_s1_post_steps == '0)
                             : (r_in_post && (w_post_dec == '0));

    // Correctness follows the sign of the decision drift as it stood at the decision.
    assign w_resp   = w_decide ? w_hit_up : r_chose_upper;
    assign w_corr   = w_decide ? (w_hit_up ? (r_drift > 0) : (r_drift < 0)) : r_was_correct;
    assign w_dec_nx = w_decide ? w_cnt_nx : r_dec_steps;

    assign w_conf_raw = w_resp ?
        ({{2{w_level_nx[LW-1]}}, w_level_nx} - $signed({3'b000, r_upper_bound})) :
        (-{{2{w_level_nx[LW-1]}}, w_level_nx});

    ddts_time_out #(.TIME_BITS(TIME_BITS)) u_dec_time (
        .i_steps (w_dec_nx),
        .i_extra (r_nd_steps),
        .o_time  (w_dec_time)
    );

    ddts_time_out #(.TIME_BITS(TIME_BITS)) u_tot_time (
        .i_steps (w_cnt_nx),
        .i_extra (r_nd_steps),
        .o_time  (w_tot_time)
    );

    always_comb begin
        w_result                = '0;
        w_result.decision_time  = w_dec_time;
        w_result.response       = w_resp;
        w_result.correct        = w_corr;
        w_result.final_evidence = w_level_nx;
        w_result.total_time     = w_tot_time;
        w_result.confidence     = sat_level(w_conf_raw);
    end

    // A step moves on whenever the output register is free or being emptied.
    logic              r_m_valid;
    ddts_pkg::t_result r_m_data;

    assign w_adv      = r_s1_valid && (!r_m_valid || i_m_tready);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count  <= '0;
            r_dec_steps   <= '0;
            r_in_post     <= 1'b0;
            r_chose_upper <= 1'b0;
            r_was_correct <= 1'b0;
            r_post_left   <= '0;
        end else if (w_adv) begin
            if (w_emit) begin
                // The trial is complete; the next step starts a fresh one.
                r_step_count  <= '0;
                r_dec_steps   <= '0;
                r_in_post     <= 1'b0;
                r_chose_upper <= 1'b0;
                r_was_correct <= 1'b0;
                r_post_left   <= '0;
            end else begin
                r_step_count <= w_cnt_nx;
                if (w_decide) begin
                    r_in_post     <= 1'b1;
                    r_chose_upper <= w_hit_up;
                    r_was_correct <= w_corr;
                    r_dec_steps   <= w_cnt_nx;
                    r_post_left   <= r_s1_post_steps;
                end else if (r_in_post) begin
                    r_post_left <= w_post_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_level <= w_level_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= w_emit;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_m_data <= w_result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_post_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_post |-> (r_post_left != '0))
        else $error("post phase entered with no post steps left");

    a_post_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_post |-> (r_step_count != '0) && (r_dec_steps <= r_step_count))
        else $error("decision step count inconsistent with step count");

    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (!r_in_post && (r_step_count == '0) && r_m_valid))
        else $error("trial not restarted after its result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |-> !w_adv)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    // Indexes outside the register map; writes to them must leave every register alone.
    localparam logic [ddts_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [ddts_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint LEVEL_MAX = 64'sd2147483647;
    localparam longint LEVEL_MIN = -LEVEL_MAX - 1;
    localparam longint TIME_MAX  = 64'sd4294967295;

    // Extra wait that lets the pipeline empty after steps that end no trial.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_STEPS  = 1350;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [ddts_pkg::S_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [ddts_pkg::M_TDATA_W-1:0]   o_m_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [ddts_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [ddts_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    drift_diffusion_trial_stepper_core #(
        .TIME_BITS (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers, held at full precision.
    longint drift_q      = 0;
    longint post_drift_q = 0;
    longint scale_q      = 0;
    longint bound_q      = 65536;
    longint start_q      = 32768;
    longint ndt_q        = 0;

    // Running state of the trial in progress.
    typedef struct {
        longint      level;
        longint      steps;
        longint      dec_steps;
        bit          post_phase;
        bit          upper;
        bit          correct;
        logic [15:0] post_left;
    } t_trial;

    t_trial trial;

    // Results still owed by the block, oldest first.
    ddts_pkg::t_result owed_results[$];

    // One row of the directed sequence: either a register write or a step, where a step
    // may carry a result that is written out by hand.
    typedef struct {
        bit                               is_cfg;
        logic [ddts_pkg::CFG_INDEX_W-1:0] idx;
        logic [ddts_pkg::CFG_DATA_W-1:0]  data;
        logic [15:0]                      noise;
        logic [15:0]                      post;
        bit                               typed;
        ddts_pkg::t_result                want;
    } t_plan_row;

    t_plan_row plan[$];

    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  steps_sent      = 0;
    int  reg_writes      = 0;
    bit  quiet           = 1'b0;
    bit  cfg_open        = 1'b0;

    function automatic void start_trial();
        trial.level      = start_q;
        trial.steps      = 0;
        trial.dec_steps  = 0;
        trial.post_phase = 1'b0;
        trial.upper      = 1'b0;
        trial.correct    = 1'b0;
        trial.post_left  = '0;
    endfunction

    function automatic longint clamp_level(longint x);
        if (x > LEVEL_MAX) return LEVEL_MAX;
        if (x < LEVEL_MIN) return LEVEL_MIN;
        return x;
    endfunction

    function automatic longint clamp_time(longint x);
        return (x > TIME_MAX) ? TIME_MAX : x;
    endfunction

    function automatic void apply_reg(logic [ddts_pkg::CFG_INDEX_W-1:0] idx,
                                      logic [ddts_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ddts_pkg::CFG_DRIFT_STEP:
                drift_q      = longint'(signed'(data));
            ddts_pkg::CFG_POST_DRIFT_STEP:
                post_drift_q = longint'(signed'(data));
            ddts_pkg::CFG_NOISE_SCALE:
                scale_q      = longint'(data[ddts_pkg::SCALE_W-1:0]);
            ddts_pkg::CFG_UPPER_BOUND:
                bound_q      = longint'(data[ddts_pkg::BOUND_W-1:0]);
            ddts_pkg::CFG_START_LEVEL:
                start_q      = longint'(data[ddts_pkg::BOUND_W-1:0]);
            ddts_pkg::CFG_NONDECISION_STEPS:
                ndt_q        = longint'(data[ddts_pkg::NDT_W-1:0]);
            default: ;
        endcase
    endfunction

    // Advances the trial by one step. Returns 1 when the step ends the trial, in which
    // case the finished result is handed back and a fresh trial is started.
    function automatic bit advance_trial(logic [15:0] noise, logic [15:0] post,
                                         output ddts_pkg::t_result res);
        longint term;
        longint base;
        res  = '0;
        // An arithmetic shift of the exact product rounds towards minus infinity.
        term = (longint'(signed'(noise)) * scale_q) >>> 12;
        if (!trial.post_phase) begin
            base        = (trial.steps == 0) ? start_q : trial.level;
            trial.steps = clamp_time(trial.steps + 1);
            trial.level = clamp_level(base + drift_q + term);
            if (trial.level >= bound_q) begin
                trial.level   = bound_q;
                trial.upper   = 1'b1;
                trial.correct = (drift_q > 0);
            end else if (trial.level <= 0) begin
                trial.level   = 0;
                trial.upper   = 1'b0;
                trial.correct = (drift_q < 0);
            end else begin
                return 1'b0;
            end
            trial.dec_steps = trial.steps;
            trial.post_left = post;
            if (post != 0) begin
                trial.post_phase = 1'b1;
                return 1'b0;
            end
        end else begin
            trial.steps     = clamp_time(trial.steps + 1);
            trial.level     = clamp_level(trial.level + post_drift_q + term);
            trial.post_left = trial.post_left - 16'd1;
            if (trial.post_left != 0) return 1'b0;
        end
        res.decision_time  = 32'(clamp_time(trial.dec_steps + ndt_q));
        res.response       = trial.upper;
        res.correct        = trial.correct;
        res.final_evidence = trial.level[31:0];
        res.total_time     = 32'(clamp_time(trial.steps + ndt_q));
        res.confidence     = 32'(trial.upper ? clamp_level(trial.level - bound_q)
                                             : clamp_level(-trial.level));
        start_trial();
        return 1'b1;
    endfunction

    // True when this noise sample would make the current trial reach a bound.
    function automatic bit would_decide(logic [15:0] noise);
        t_trial            keep;
        ddts_pkg::t_result unused;
        bit                hit;
        keep  = trial;
        hit   = !trial.post_phase && advance_trial(noise, 16'd0, unused);
        trial = keep;
        return hit;
    endfunction

    function automatic ddts_pkg::t_result mk_result(logic [31:0] dec_time, bit resp,
                                                    bit corr, logic [31:0] evidence,
                                                    logic [31:0] tot_time,
                                                    logic [31:0] conf);
        ddts_pkg::t_result r;
        r                = '0;
        r.decision_time  = dec_time;
        r.response       = resp;
        r.correct        = corr;
        r.final_evidence = evidence;
        r.total_time     = tot_time;
        r.confidence     = conf;
        return r;
    endfunction

    function automatic void add_cfg(logic [ddts_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [ddts_pkg::CFG_DATA_W-1:0] data);
        t_plan_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        plan.push_back(row);
    endfunction

    function automatic void add_step(logic [15:0] noise, logic [15:0] post);
        t_plan_row row;
        row       = '{default: '0};
        row.noise = noise;
        row.post  = post;
        plan.push_back(row);
    endfunction

    function automatic void add_checked(logic [15:0] noise, logic [15:0] post,
                                        ddts_pkg::t_result want);
        t_plan_row row;
        row       = '{default: '0};
        row.noise = noise;
        row.post  = post;
        row.typed = 1'b1;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic logic [15:0] any16();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    // Mostly a rough bell shape of a few units in Q4.12, with some fully random words and
    // the two extremes now and then.
    function automatic logic [15:0] draw_noise();
        int v;
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return any16();
            default: begin
                v = $urandom_range(0, 8192) + $urandom_range(0, 8192) - 8192;
                return v[15:0];
            end
        endcase
    endfunction

    // Post-decision lengths are kept short so that many trials finish; the rare long
    // one still exercises the countdown up to bit 9.
    function automatic logic [15:0] draw_post();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 16'd0;
        if (r < 85) return 16'($urandom_range(1, 8));
        if (r < 97) return 16'($urandom_range(9, 64));
        return 16'($urandom_range(65, 1023));
    endfunction

    // Offers one step and, once the transfer has happened, works out what it causes.
    // The valid is only lowered when a gap follows, so it never drops and rises within
    // the same time step.
    task automatic send_step(input logic [15:0] noise, input logic [15:0] post,
                             input bit typed, input ddts_pkg::t_result want);
        int                gap;
        bit                ended;
        ddts_pkg::t_result res;
        gap = draw_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {post, noise};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        steps_sent++;
        ended = advance_trial(noise, post, res);
        if (typed)
            owed_results.push_back(want);
        else if (ended)
            owed_results.push_back(res);
    endtask

    // Leaves the valid high across back-to-back writes; the caller lowers it afterwards.
    task automatic write_reg(input logic [ddts_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ddts_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        reg_writes++;
        apply_reg(idx, data);
    endtask

    // Waits until the block has delivered every result it owes and has had time to
    // absorb any trailing steps that end no trial.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Picks a fresh register set for one random phase. Bits above a register's width
    // are filled with junk, which the block has to drop.
    task automatic new_setting();
        logic [31:0] bound;
        logic [31:0] start;
        logic [31:0] drift;
        logic [31:0] post_drift;
        logic [31:0] scale;
        logic [31:0] ndt;
        logic [31:0] junk;
        case ($urandom_range(0, 9))
            0:       bound = 32'd0;
            1:       bound = 32'h7FFF_FFFF;
            default: bound = $urandom_range(16384, 262144);
        endcase
        case ($urandom_range(0, 9))
            0:       start = 32'd0;
            1:       start = 32'h7FFF_FFFF;
            default: start = (bound > 2) ? $urandom_range(1, bound - 1)
                                         : $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 9))
            0:       drift = 32'h8000_0000;
            1:       drift = 32'h7FFF_FFFF;
            2:       drift = 32'd0;
            default: drift = $urandom_range(0, 8000) - 4000;
        endcase
        case ($urandom_range(0, 9))
            0:       post_drift = 32'h8000_0000;
            1:       post_drift = 32'h7FFF_FFFF;
            2:       post_drift = $urandom;
            default: post_drift = $urandom_range(0, 8000) - 4000;
        endcase
        case ($urandom_range(0, 9))
            0:       scale = 32'd0;
            1:       scale = 32'hFFFF;
            default: scale = $urandom_range(4096, 65535);
        endcase
        case ($urandom_range(0, 9))
            0:       ndt = 32'd0;
            1:       ndt = 32'hFF_FFFF;
            default: ndt = $urandom_range(0, 1000);
        endcase
        junk = $urandom;
        write_reg(ddts_pkg::CFG_UPPER_BOUND,       {junk[31], bound[30:0]});
        write_reg(ddts_pkg::CFG_START_LEVEL,       {junk[30], start[30:0]});
        write_reg(ddts_pkg::CFG_DRIFT_STEP,        drift);
        write_reg(ddts_pkg::CFG_POST_DRIFT_STEP,   post_drift);
        write_reg(ddts_pkg::CFG_NOISE_SCALE,       {junk[15:0], scale[15:0]});
        write_reg(ddts_pkg::CFG_NONDECISION_STEPS, {junk[23:16], ndt[23:0]});
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: may stall for a random number of cycles before each transfer and checks
    // each result against the oldest one still owed.
    initial begin : result_side
        int                gap;
        ddts_pkg::t_result got;
        ddts_pkg::t_result want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            got = o_m_tdata;
            if (owed_results.size() == 0) begin
                $error("result transfer arrived while no trial result was owed");
                mismatch_count++;
            end else begin
                want = owed_results.pop_front();
                results_checked++;
                check_field("decision_time",  want.decision_time,  got.decision_time);
                check_field("response",       want.response,       got.response);
                check_field("correct",        want.correct,        got.correct);
                check_field("final_evidence", want.final_evidence, got.final_evidence);
                check_field("total_time",     want.total_time,     got.total_time);
                check_field("confidence",     want.confidence,     got.confidence);
                check_field("pad",            want.pad,            got.pad);
            end
        end
    end

    // Stimulus: directed sequence first, then phases of random trials.
    initial begin : step_side
        int          phase_len;
        int          random_steps;
        int          directed_steps;
        logic [15:0] noise;
        logic [15:0] post;

        start_trial();

        // Straight after reset there is no noise scaling and no drift, so the evidence
        // sits at the start level and nothing is decided.
        add_step(16'h7FFF, 16'hFFFF);
        // Largest drift: the sum saturates and is clamped to the upper bound.
        add_cfg(ddts_pkg::CFG_DRIFT_STEP, 32'h7FFF_FFFF);
        add_checked(16'h8000, 16'd0, mk_result(32'd2, 1'b1, 1'b1, 32'd65536, 32'd2, 32'd0));
        // Most negative drift: the next trial falls to zero on its first step.
        add_cfg(ddts_pkg::CFG_DRIFT_STEP, 32'h8000_0000);
        add_checked(16'h0000, 16'd0, mk_result(32'd1, 1'b0, 1'b1, 32'd0, 32'd1, 32'd0));
        // A zero bound decides upwards at once; zero drift means the answer is never
        // correct. The post step then pushes the evidence into positive saturation, and
        // the non-decision time at its maximum (written with junk above bit 23) is added.
        add_cfg(ddts_pkg::CFG_DRIFT_STEP, 32'h0000_0000);
        add_cfg(ddts_pkg::CFG_POST_DRIFT_STEP, 32'h7FFF_FFFF);
        add_cfg(ddts_pkg::CFG_UPPER_BOUND, 32'h0000_0000);
        add_cfg(ddts_pkg::CFG_NONDECISION_STEPS, 32'hFFFF_FFFF);
        add_step(16'h0000, 16'd1);
        add_checked(16'h0000, 16'd0, mk_result(32'h0100_0000, 1'b1, 1'b0, 32'h7FFF_FFFF,
                                               32'h0100_0001, 32'h7FFF_FFFF));
        // Starting at zero decides downwards; two post steps drive the evidence into
        // negative saturation, and negating it for the confidence saturates as well.
        add_cfg(ddts_pkg::CFG_POST_DRIFT_STEP, 32'h8000_0000);
        add_cfg(ddts_pkg::CFG_UPPER_BOUND, 32'hFFFF_FFFF);
        add_cfg(ddts_pkg::CFG_START_LEVEL, 32'h8000_0000);
        add_step(16'h0000, 16'd2);
        add_step(16'h5A5A, 16'hFFFF);
        add_checked(16'h0000, 16'd0, mk_result(32'h0100_0000, 1'b0, 1'b0, 32'h8000_0000,
                                               32'h0100_0002, 32'h7FFF_FFFF));
        // Writes to indexes outside the map must change nothing.
        add_cfg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        add_cfg(CFG_SPARE_HI, 32'h1234_5678);
        // Full-scale noise, both extremes, and the smallest samples of either sign to show
        // rounding towards minus infinity.
        add_cfg(ddts_pkg::CFG_NOISE_SCALE, 32'h0000_FFFF);
        add_cfg(ddts_pkg::CFG_POST_DRIFT_STEP, 32'h0000_0000);
        add_cfg(ddts_pkg::CFG_START_LEVEL, 32'h4000_0000);
        add_cfg(ddts_pkg::CFG_NONDECISION_STEPS, 32'h0000_0000);
        add_step(16'h7FFF, 16'hFFFF);
        add_step(16'h8000, 16'h0000);
        add_step(16'h0001, 16'h8000);
        add_step(16'hFFFF, 16'h7FFF);
        // Drift changed mid-trial: the next step sees it and decides downwards.
        add_cfg(ddts_pkg::CFG_DRIFT_STEP, 32'h8000_0000);
        add_step(16'h7FFF, 16'd3);
        add_step(16'h8000, 16'd0);
        add_step(16'h7FFF, 16'd0);
        add_step(16'h1234, 16'd0);
        // A new start level written mid-trial waits for the next trial.
        add_cfg(ddts_pkg::CFG_DRIFT_STEP, 32'h0000_0000);
        add_cfg(ddts_pkg::CFG_NOISE_SCALE, 32'h0000_0000);
        add_cfg(ddts_pkg::CFG_UPPER_BOUND, 32'h0001_0000);
        add_cfg(ddts_pkg::CFG_START_LEVEL, 32'h0000_8000);
        add_cfg(ddts_pkg::CFG_NONDECISION_STEPS, 32'h0000_0005);
        add_step(16'h0000, 16'd0);
        add_cfg(ddts_pkg::CFG_START_LEVEL, 32'h0001_0000);
        add_step(16'h0000, 16'd0);
        add_cfg(ddts_pkg::CFG_DRIFT_STEP, 32'h0000_8000);
        add_checked(16'h0000, 16'd0, mk_result(32'd8, 1'b1, 1'b1, 32'd65536, 32'd8, 32'd0));
        add_step(16'h0000, 16'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!cfg_open) begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_step(plan[i].noise, plan[i].post, plan[i].typed, plan[i].want);
            end
        end
        directed_steps = steps_sent;

        // Random phases: each one settles the block, loads a new register set and then
        // runs a stream of trials. About one phase in four runs without any idling.
        random_steps = 0;
        while (random_steps < RANDOM_STEPS) begin
            settle();
            new_setting();
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(100, 200);
            if (phase_len > RANDOM_STEPS - random_steps)
                phase_len = RANDOM_STEPS - random_steps;
            repeat (phase_len) begin
                noise = draw_noise();
                // The post length only counts on the deciding step; elsewhere it is noise.
                post  = would_decide(noise) ? draw_post() : any16();
                send_step(noise, post, 1'b0, '0);
                random_steps++;
            end
        end
        quiet = 1'b0;

        settle();
        $display("Sent %0d steps (%0d directed) with %0d register writes; checked %0d results.",
                 steps_sent, directed_steps, reg_writes, results_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of a few thousand steps.
    initial begin : watchdog
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- drift_diffusion_trial_stepper_core.f -----
rtl/ddts_pkg.sv
rtl/ddts_time_out.sv
rtl/drift_diffusion_trial_stepper_core.sv
tb/tb_top.sv
